FILE: design/imu_gyro_accel_time_aligner_macros.svh
// Assertion macros used by the time aligner back end.
`ifndef IMU_GYRO_ACCEL_TIME_ALIGNER_MACROS_SVH
`define IMU_GYRO_ACCEL_TIME_ALIGNER_MACROS_SVH
`ifndef SYNTH
`define ALN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ALN_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ALN_ASSERT(lbl, prop, msg)
`define ALN_NEVER(lbl, cond, msg)
`endif
`endif

FILE: design/aln_pkg.sv
// Types, constants and helpers of the gyro/accel time aligner.
package aln_pkg;

  localparam int GYRO_DEPTH  = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int MAX_RESULTS = 16;
  localparam int HW          = $clog2(GYRO_DEPTH);
  localparam int CW          = $clog2(GYRO_DEPTH + 1);
  localparam int NW          = $clog2(MAX_RESULTS + 1);
  localparam int TW          = 62;
  localparam int WW          = 16;

  typedef enum logic [1:0] {
    OP_GYRO     = 2'd0,
    OP_ACCEL    = 2'd1,
    OP_COMBINED = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_DROP,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_ADD
  } st_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [TW-1:0]      sample_time;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic signed [31:0] gyro_x;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic [TW-1:0]      out_time;
    logic signed [31:0] out_accel_x;
    logic signed [31:0] out_accel_y;
    logic signed [31:0] out_accel_z;
    logic signed [31:0] out_gyro_x;
    logic signed [31:0] out_gyro_y;
    logic signed [31:0] out_gyro_z;
    logic               last_of_run;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } cmd_t;

  function automatic logic signed [31:0] sext_val(input logic [31:0] raw);
    logic signed [VALUE_WIDTH-1:0] v;
    v = raw[VALUE_WIDTH-1:0];
    return 32'(v);
  endfunction

endpackage

FILE: design/aln_in_if.sv
// Input channel interface of the time aligner.
interface aln_in_if;
  import aln_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/aln_out_if.sv
// Result channel interface of the time aligner.
interface aln_out_if;
  import aln_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/imu_gyro_accel_time_aligner.sv
// Gyro/accelerometer time aligner: gyro words queue (16 deep, a full queue drops
// its oldest) until an accelerometer word brackets them; each such gyro word is
// emitted with acceleration linearly interpolated between the previous and the
// current accelerometer word, up to 16 results per accelerometer word, the last
// marked by last_of_run. Combined words pass through as one result. For a later
// accelerometer word the back end first discards queued entries older than the
// previous accelerometer word, then for each result runs the 16-step restoring
// divider for the weight (skipped for a result whose weight is zero) and a
// multiply and an add step per axis on the shared multiplier; a result can be
// held back by a stall on the output. A two-word command queue lets the input
// side keep accepting while the back end works.
module imu_gyro_accel_time_aligner (
  input  logic      clk,
  input  logic      rst_n,
  aln_in_if.sink    in_if,
  aln_out_if.source out_if
);
  import aln_pkg::*;

  cmd_t cmd;
  logic cmd_pop;

  aln_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .cmd     (cmd),
    .cmd_pop (cmd_pop)
  );

  aln_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .cmd_pop (cmd_pop),
    .out_if  (out_if)
  );

endmodule

FILE: design/aln_front.sv
// Front end: accepts input words, drops unused codes, queues commands.
module aln_front (
  input  logic          clk,
  input  logic          rst_n,
  aln_in_if.sink        in_if,
  output aln_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import aln_pkg::*;

  in_item_t   mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_if.ready = (cnt_r != 2'd2);
  assign push = in_if.valid && in_if.ready && (in_if.data.op != OP_UNUSED);

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = cmd_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_if.data;
    end
  end

  assign cmd.valid = (cnt_r != 2'd0);
  assign cmd.item  = mem_r[rp_r];

endmodule

FILE: design/aln_back.sv
// Back end: gyro queue, interpolation sequencer and result register.
`include "imu_gyro_accel_time_aligner_macros.svh"
module aln_back (
  input  logic          clk,
  input  logic          rst_n,
  input  aln_pkg::cmd_t cmd,
  output logic          cmd_pop,
  aln_out_if.source     out_if
);
  import aln_pkg::*;

  logic [TW-1:0]      gt_r [GYRO_DEPTH];
  logic signed [31:0] gv_r [GYRO_DEPTH][3];

  st_t                state_r, state_nxt;
  logic [HW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic               pv_r, pv_nxt;
  logic [TW-1:0]      tp_r, tp_nxt;
  logic signed [31:0] pa_r [3];
  logic signed [31:0] pa_nxt [3];
  logic [TW:0]        rem_r, rem_nxt;
  logic [TW-1:0]      den_r, den_nxt;
  logic [WW-1:0]      q_r, q_nxt;
  logic [3:0]         dc_r, dc_nxt;
  logic [1:0]         ax_r, ax_nxt;
  logic signed [49:0] prod_r, prod_nxt;
  logic signed [31:0] base_r, base_nxt;
  logic               rv_r, rv_nxt;
  logic [TW-1:0]      rt_r, rt_nxt;
  logic signed [31:0] ra_r [3];
  logic signed [31:0] ra_nxt [3];
  logic signed [31:0] rg_r [3];
  logic signed [31:0] rg_nxt [3];
  logic               ov_r, ov_nxt;
  out_item_t          od_r, od_nxt;

  logic               gwe;
  logic [HW-1:0]      slot;
  logic [CW:0]        slot_sum;
  logic [HW-1:0]      head_inc;
  logic [TW-1:0]      head_t;
  logic [TW-1:0]      tn;
  logic               nonempty, cont, out_free, can_push;
  logic signed [31:0] ca [3];
  logic signed [31:0] cg [3];
  logic signed [32:0] diff;
  logic signed [50:0] sum;
  logic [TW:0]        r2;

  assign tn       = cmd.item.sample_time;
  assign head_t   = gt_r[head_r];
  assign nonempty = (cnt_r != '0);
  assign cont     = nonempty && (n_r < NW'(MAX_RESULTS)) && (head_t < tn);
  assign out_free = !ov_r || out_if.ready;
  assign can_push = !rv_r || out_free;
  assign head_inc = (head_r == HW'(GYRO_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign ca[0] = sext_val(cmd.item.accel_x);
  assign ca[1] = sext_val(cmd.item.accel_y);
  assign ca[2] = sext_val(cmd.item.accel_z);
  assign cg[0] = sext_val(cmd.item.gyro_x);
  assign cg[1] = sext_val(cmd.item.gyro_y);
  assign cg[2] = sext_val(cmd.item.gyro_z);

  always_comb begin
    slot_sum = (CW + 1)'(head_r) + (CW + 1)'(cnt_r);
    if (slot_sum >= (CW + 1)'(GYRO_DEPTH)) begin
      slot_sum = slot_sum - (CW + 1)'(GYRO_DEPTH);
    end
    slot = slot_sum[HW-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.valid) begin
          case (op_t'(cmd.item.op))
            OP_ACCEL:    state_nxt = pv_r ? ST_DROP : ST_IDLE;
            OP_COMBINED: state_nxt = ST_PASS;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PASS:  state_nxt = out_free ? ST_IDLE : ST_PASS;
      ST_DROP:  state_nxt = (nonempty && head_t < tp_r) ? ST_DROP : ST_CHECK;
      ST_CHECK: begin
        if (can_push) begin
          if (!cont) begin
            state_nxt = ST_IDLE;
          end else if (head_t > tp_r) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_DIV:   state_nxt = (dc_r == 4'd15) ? ST_MUL : ST_DIV;
      ST_MUL:   state_nxt = ST_ADD;
      ST_ADD:   state_nxt = (ax_r == 2'd2) ? ST_CHECK : ST_MUL;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    pv_nxt   = pv_r;
    tp_nxt   = tp_r;
    pa_nxt   = pa_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    dc_nxt   = dc_r;
    ax_nxt   = ax_r;
    prod_nxt = prod_r;
    base_nxt = base_r;
    rv_nxt   = rv_r;
    rt_nxt   = rt_r;
    ra_nxt   = ra_r;
    rg_nxt   = rg_r;
    ov_nxt   = out_if.ready ? 1'b0 : ov_r;
    od_nxt   = od_r;
    cmd_pop  = 1'b0;
    gwe      = 1'b0;
    diff     = '0;
    sum      = '0;
    r2       = '0;
    case (state_r)
      ST_IDLE: begin
        if (cmd.valid) begin
          case (op_t'(cmd.item.op))
            OP_GYRO: begin
              gwe     = 1'b1;
              cmd_pop = 1'b1;
              // full queue: drop oldest, its slot takes the new word
              if (cnt_r == CW'(GYRO_DEPTH)) begin
                head_nxt = head_inc;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            OP_ACCEL: begin
              n_nxt = '0;
              if (!pv_r) begin
                pv_nxt  = 1'b1;
                tp_nxt  = tn;
                pa_nxt  = ca;
                cmd_pop = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PASS: begin
        if (out_free) begin
          ov_nxt             = 1'b1;
          od_nxt.out_time    = tn;
          od_nxt.out_accel_x = ca[0];
          od_nxt.out_accel_y = ca[1];
          od_nxt.out_accel_z = ca[2];
          od_nxt.out_gyro_x  = cg[0];
          od_nxt.out_gyro_y  = cg[1];
          od_nxt.out_gyro_z  = cg[2];
          od_nxt.last_of_run = 1'b1;
          cmd_pop            = 1'b1;
        end
      end
      ST_DROP: begin
        if (nonempty && head_t < tp_r) begin
          head_nxt = head_inc;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      ST_CHECK: begin
        if (can_push) begin
          // release the held result once it is known whether more follow
          if (rv_r) begin
            ov_nxt             = 1'b1;
            od_nxt.out_time    = rt_r;
            od_nxt.out_accel_x = ra_r[0];
            od_nxt.out_accel_y = ra_r[1];
            od_nxt.out_accel_z = ra_r[2];
            od_nxt.out_gyro_x  = rg_r[0];
            od_nxt.out_gyro_y  = rg_r[1];
            od_nxt.out_gyro_z  = rg_r[2];
            od_nxt.last_of_run = !cont;
            rv_nxt             = 1'b0;
          end
          ax_nxt = 2'd0;
          q_nxt  = '0;
          dc_nxt = '0;
          if (!cont) begin
            pv_nxt  = 1'b1;
            tp_nxt  = tn;
            pa_nxt  = ca;
            cmd_pop = 1'b1;
          end else begin
            rem_nxt = (TW + 1)'(head_t - tp_r);
            den_nxt = tn - tp_r;
          end
        end
      end
      ST_DIV: begin
        r2 = {rem_r[TW-1:0], 1'b0};
        if (r2 >= {1'b0, den_r}) begin
          rem_nxt = r2 - {1'b0, den_r};
          q_nxt   = {q_r[WW-2:0], 1'b1};
        end else begin
          rem_nxt = r2;
          q_nxt   = {q_r[WW-2:0], 1'b0};
        end
        dc_nxt = dc_r + 1'b1;
      end
      ST_MUL: begin
        diff     = 33'(ca[ax_r]) - 33'(pa_r[ax_r]);
        prod_nxt = 50'(diff) * 50'($signed({1'b0, q_r}));
        base_nxt = pa_r[ax_r];
      end
      ST_ADD: begin
        sum = {{3{base_r[31]}}, base_r, 16'b0} + 51'(prod_r);
        ra_nxt[ax_r] = sum[47:16];
        if (ax_r == 2'd2) begin
          rv_nxt   = 1'b1;
          rt_nxt   = head_t;
          rg_nxt   = gv_r[head_r];
          head_nxt = head_inc;
          cnt_nxt  = cnt_r - 1'b1;
          n_nxt    = n_r + 1'b1;
        end else begin
          ax_nxt = ax_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      cnt_r   <= '0;
      n_r     <= '0;
      pv_r    <= 1'b0;
      tp_r    <= '0;
      pa_r    <= '{default: '0};
      rv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      pv_r    <= pv_nxt;
      tp_r    <= tp_nxt;
      pa_r    <= pa_nxt;
      rv_r    <= rv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
    dc_r   <= dc_nxt;
    ax_r   <= ax_nxt;
    prod_r <= prod_nxt;
    base_r <= base_nxt;
    rt_r   <= rt_nxt;
    ra_r   <= ra_nxt;
    rg_r   <= rg_nxt;
    od_r   <= od_nxt;
    if (gwe) begin
      gt_r[slot] <= tn;
      gv_r[slot] <= cg;
    end
  end

  assign out_if.valid = ov_r;
  assign out_if.data  = od_r;

  `ALN_NEVER(a_cnt_bound, cnt_r > CW'(GYRO_DEPTH), "gyro queue count beyond depth")
  `ALN_NEVER(a_n_bound, n_r > NW'(MAX_RESULTS), "result count beyond limit")
  `ALN_ASSERT(a_div_rem, (state_r == ST_DIV) |-> (rem_r < {1'b0, den_r}), "bad remainder")
  `ALN_NEVER(a_idle_held, (state_r == ST_IDLE) && rv_r, "held result left behind in idle")
  `ALN_ASSERT(a_pop_gyro, $rose(rv_r) |-> (cnt_r == $past(cnt_r) - 1'b1), "emit without queue pop")

endmodule
